FILE: src/modular_exponentiation_core_defines.svh
// Assertion macros shared by the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/mec_pkg.sv
// Shared types and register codes of the modular exponentiation core.
`default_nettype none
package mec_pkg;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 1'b1;

   typedef struct packed {
      logic start;
   } mm_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;
endpackage
`default_nettype wire

FILE: src/mec_exp_cell.sv
// One exponent bit cell: loads a bit, hands it down the row on each shift.
`default_nettype none
module mec_exp_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic shift,
   input  wire logic load_bit,
   input  wire logic upper_bit,
   output logic      bit_out
);
   logic bit_ff, bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = upper_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;
endmodule
`default_nettype wire

FILE: src/mec_modmul.sv
// Bit-serial modular multiplier: a*b mod m, one multiplier bit per cycle, MSB first.
`default_nettype none
module mec_modmul
   import mec_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mm_ctl_type              ctl,
   input  wire logic [OPERAND_BITS-1:0] addend,
   input  wire logic [OPERAND_BITS-1:0] multiplier,
   input  wire logic [OPERAND_BITS-1:0] modulus,
   output mm_status_type                status,
   output logic [OPERAND_BITS-1:0]      product
);
   localparam int CNT_BITS = $clog2(OPERAND_BITS + 1);

   logic [OPERAND_BITS-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [OPERAND_BITS:0]   dbl, dbl_red, sum, sum_red;

   always_comb begin
      // Double, reduce once; add addend (<= m), reduce once.
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + (b_ff[OPERAND_BITS-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;

      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in = '0;
         a_in   = addend;
         b_in   = multiplier;
         cnt_in = CNT_BITS'(OPERAND_BITS);
      end else if (cnt_ff != '0) begin
         acc_in  = sum_red[OPERAND_BITS-1:0];
         b_in    = {b_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign product     = acc_ff;
endmodule
`default_nettype wire

FILE: src/modular_exponentiation_core.sv
// Top level of the modular exponentiation core (right-to-left square-and-multiply).
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| req_base_value
//   rsp     | out       | rsp_valid/rsp_stall| rsp_power_result
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One transaction at a time: the base is reduced first, then each exponent bit up
// to the highest set one takes one pass of the bit-serial modular multipliers
// (square and multiply run in parallel). A zero exponent or zero modulus skips
// the multipliers and goes straight to the finish state. Reset is synchronous
// and restores modulus 1, exponent 0. A stalled result holds in the output
// register while the next request is already accepted.
`default_nettype none
`include "modular_exponentiation_core_defines.svh"
module modular_exponentiation_core
   import mec_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [OPERAND_BITS-1:0]   req_base_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [OPERAND_BITS-1:0]        rsp_power_result,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [OPERAND_BITS-1:0]   csr_write_data
);
   typedef enum logic [1:0] {ST_IDLE, ST_REDUCE, ST_MUL, ST_FINISH} state_type;

   state_type               state_ff, state_in;
   logic [OPERAND_BITS-1:0] modulus_ff, modulus_in, exponent_ff, exponent_in;
   logic [OPERAND_BITS-1:0] res_ff, res_in, sq_ff, sq_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] rsp_data_ff, rsp_data_in;

   mm_ctl_type              mul_ctl, sqr_ctl;
   mm_status_type           mul_stat, sqr_stat;
   logic [OPERAND_BITS-1:0] mul_prod, sqr_prod, sqr_addend, sqr_mult;

   logic                    cells_load, cells_shift;
   logic [OPERAND_BITS-1:0] exp_bits;
   logic                    req_take, rsp_free, exp_rest;

   // Exponent row: cell 0 holds the bit in use, higher bits shift down.
   for (genvar i = 0; i < OPERAND_BITS; i++) begin : g_cell
      logic upper;
      if (i == OPERAND_BITS - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = exp_bits[i+1];
      end
      mec_exp_cell u_cell (
         .clock    (clock),
         .load     (cells_load),
         .shift    (cells_shift),
         .load_bit (exponent_ff[i]),
         .upper_bit(upper),
         .bit_out  (exp_bits[i])
      );
   end

   // Any set bit left above the one in use.
   assign exp_rest = |exp_bits[OPERAND_BITS-1:1];

   // The multiply starts on the edge that updates res and sq, so feed it the new values.
   mec_modmul #(.OPERAND_BITS(OPERAND_BITS)) u_mul (
      .clock(clock), .reset(reset), .ctl(mul_ctl),
      .addend(res_in), .multiplier(sq_in), .modulus(modulus_ff),
      .status(mul_stat), .product(mul_prod)
   );

   mec_modmul #(.OPERAND_BITS(OPERAND_BITS)) u_sqr (
      .clock(clock), .reset(reset), .ctl(sqr_ctl),
      .addend(sqr_addend), .multiplier(sqr_mult), .modulus(modulus_ff),
      .status(sqr_stat), .product(sqr_prod)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      exponent_in  = exponent_ff;
      res_in       = res_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_ctl      = '0;
      sqr_ctl      = '0;
      cells_load   = 1'b0;
      cells_shift  = 1'b0;
      // Reduction reuses the squarer as 1 * base mod m.
      sqr_addend   = OPERAND_BITS'(1);
      sqr_mult     = req_base_value;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_write_data;
            CSR_EXPONENT: exponent_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cells_load = 1'b1;
               if (exponent_ff == '0) begin
                  res_in   = OPERAND_BITS'(1);
                  state_in = ST_FINISH;
               end else if (modulus_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  sqr_ctl.start = 1'b1;
                  res_in   = (modulus_ff == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (sqr_stat.done) begin
               sq_in         = sqr_prod;
               mul_ctl.start = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            sqr_addend = sq_ff;
            sqr_mult   = sq_ff;
            if (mul_stat.done) begin
               if (exp_bits[0]) begin
                  res_in = mul_prod;
               end
               sq_in       = sqr_prod;
               cells_shift = 1'b1;
               if (exp_rest) begin
                  mul_ctl.start = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Squarer always runs in step with the multiplier during the scan.
      if (state_ff == ST_MUL || state_ff == ST_REDUCE) begin
         if (mul_ctl.start) begin
            sqr_ctl.start = 1'b1;
            sqr_addend    = sq_in;
            sqr_mult      = sq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= OPERAND_BITS'(1);
         exponent_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

   `MEC_ASSERT_NOW(a_done_in_work, clock, reset, sqr_stat.done, state_ff == ST_REDUCE || state_ff == ST_MUL)
   `MEC_ASSERT_NOW(a_sq_reduced, clock, reset, state_ff == ST_MUL, sq_ff < modulus_ff)
   `MEC_ASSERT_NOW(a_pair_in_step, clock, reset, state_ff == ST_MUL, mul_stat.busy == sqr_stat.busy)
   `MEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_data_ff))
endmodule
`default_nettype wire

FILE: sim/mec_checker.sv
// Scoreboard for the modular exponentiation core: predicts each power and compares results.
`default_nettype none
module mec_checker
   import mec_pkg::*;
#(
   parameter int OPERAND_BITS = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [OPERAND_BITS-1:0]   req_base_value,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic [OPERAND_BITS-1:0]   rsp_power_result,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [OPERAND_BITS-1:0]   csr_write_data,
   output int                             fail_count,
   output int                             pending_powers,
   output int                             checked_powers
);

   typedef logic [OPERAND_BITS-1:0] operand_type;

   operand_type modulus_reg;
   operand_type exponent_reg;
   operand_type expected_powers[$];

   // Right-to-left square-and-multiply at double width.
   function automatic operand_type predict_power(operand_type base_in, operand_type m,
                                                 operand_type e);
      logic [63:0] acc;
      logic [63:0] sq;
      operand_type bits_left;
      acc = 64'd1;
      bits_left = e;
      if (e == '0) return operand_type'(1);
      if (m == '0) return '0;
      sq = 64'(base_in) % 64'(m);
      acc = acc % 64'(m);
      while (bits_left != '0) begin
         if (bits_left[0]) acc = (acc * sq) % 64'(m);
         sq = (sq * sq) % 64'(m);
         bits_left = bits_left >> 1;
      end
      return operand_type'(acc);
   endfunction

   assign pending_powers = expected_powers.size();

   always @(posedge clock) begin
      if (reset) begin
         modulus_reg <= operand_type'(1);
         exponent_reg <= '0;
         expected_powers.delete();
         fail_count <= 0;
         checked_powers <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODULUS:  modulus_reg <= csr_write_data;
               CSR_EXPONENT: exponent_reg <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_powers.push_back(predict_power(req_base_value, modulus_reg, exponent_reg));
         if (rsp_valid && !rsp_stall) begin
            checked_powers <= checked_powers + 1;
            if (expected_powers.size() == 0) begin
               $error("unexpected transaction: power_result %0d", rsp_power_result);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_power_result !== expected_powers[0]) begin
                  $error("power_result mismatch: expected %0d actual %0d",
                         expected_powers[0], rsp_power_result);
                  fail_count <= fail_count + 1;
               end
               void'(expected_powers.pop_front());
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench top: drives keys and bases into the modular exponentiation core and reports.
`default_nettype none
module tb;
   import mec_pkg::*;

   localparam int OPERAND_BITS = 31;
   localparam int DRAIN_CYCLES = 1100;   // a bit over the worst-case item latency
   localparam int CYCLE_LIMIT = 3000000;
   localparam int TOTAL_ITEMS = 290;
   localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OPERAND_BITS-1:0]   req_base_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [OPERAND_BITS-1:0]   rsp_power_result;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [OPERAND_BITS-1:0]   csr_write_data;

   int fail_count;
   int pending_powers;
   int checked_powers;
   int sent_bases;
   int phase_count;
   int cycle_count;
   bit calm;            // no idling on either side while set
   bit pressure_go;     // ask the receiver for one long hold-off
   logic [OPERAND_BITS-1:0] modulus_now;

   modular_exponentiation_core #(.OPERAND_BITS(OPERAND_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_base_value(req_base_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_power_result(rsp_power_result),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   mec_checker #(.OPERAND_BITS(OPERAND_BITS)) power_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_base_value(req_base_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_power_result(rsp_power_result),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_powers(pending_powers),
      .checked_powers(checked_powers)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: abort the run if the core hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here so the core fills up
   // and pushes back on its request side.
   initial begin
      int  hold_left;
      bit  pressure_done;
      hold_left = 0;
      pressure_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
         end
      end
   end

   // Write one register; only called with nothing in flight.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [OPERAND_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MODULUS) modulus_now = value;
   endtask

   // Offer one base, idling at random first; return once the transaction is taken.
   task automatic send_base(logic [OPERAND_BITS-1:0] base_in);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base_value <= base_in;
      do @(posedge clock); while (req_stall);
      sent_bases++;
   endtask

   // Drop valid, then drain all outstanding powers so the key can change.
   task automatic settle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_powers != 0) @(posedge clock);
   endtask

   task automatic load_key(logic [OPERAND_BITS-1:0] m, logic [OPERAND_BITS-1:0] e);
      settle();
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_EXPONENT, e);
      phase_count++;
   endtask

   // Random operand of random width so small and full-size values both show up.
   function automatic logic [OPERAND_BITS-1:0] random_operand();
      logic [OPERAND_BITS-1:0] value;
      int w;
      w = $urandom_range(1, OPERAND_BITS);
      value = OPERAND_BITS'($urandom);
      if ($urandom_range(0, 3) == 0) w = OPERAND_BITS;
      return value & (OPERAND_MAX >> (OPERAND_BITS - w));
   endfunction

   // Bases biased toward zero, all-ones and the edges of the current modulus.
   function automatic logic [OPERAND_BITS-1:0] random_base();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return OPERAND_MAX;
         2: return modulus_now;
         3: return modulus_now - 1'b1;
         default: return OPERAND_BITS'($urandom);
      endcase
   endfunction

   initial begin
      logic [OPERAND_BITS-1:0] m;
      logic [OPERAND_BITS-1:0] e;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_base_value = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MODULUS;
      csr_write_data = '0;
      calm = 1'b0;
      pressure_go = 1'b0;
      sent_bases = 0;
      phase_count = 0;
      modulus_now = OPERAND_BITS'(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset key: modulus 1, exponent 0 -> always 1.
      send_base('0);
      send_base(OPERAND_MAX);

      // Largest modulus and exponent, the slowest case.
      load_key(OPERAND_MAX, OPERAND_MAX);
      send_base('0);
      send_base(31'd1);
      send_base(OPERAND_MAX);
      send_base(OPERAND_MAX - 1'b1);
      send_base(31'h2AAA_AAAA);

      // Zero exponent with modulus 1: still 1.
      load_key(31'd1, '0);
      send_base(31'd12345);
      // Modulus 1 with a nonzero exponent: everything reduces to 0.
      load_key(31'd1, 31'd5);
      send_base(31'd7);
      send_base(OPERAND_MAX);
      // Zero modulus, nonzero exponent: no reduction possible, result 0.
      load_key('0, 31'd3);
      send_base(31'd9);
      send_base(OPERAND_MAX);
      // Zero exponent with a small modulus.
      load_key(31'd13, '0);
      send_base(31'd0);
      send_base(31'd26);
      // Exponent one: plain reduction, bases at and just below the modulus, plus one mid-range value.
      load_key(OPERAND_MAX, 31'd1);
      send_base(OPERAND_MAX);
      send_base(OPERAND_MAX - 1'b1);
      send_base(31'h5555_5555);
      // Small textbook key.
      load_key(31'd3233, 31'd17);
      send_base(31'd65);
      send_base(31'd3232);
      send_base(31'd3233);
      send_base(31'd0);

      // Random keys with random bases; a quiet phase on every sixth key and one long back-pressure phase.
      while (sent_bases < TOTAL_ITEMS) begin
         m = random_operand();
         if (m == '0) m = 31'd1;
         case ($urandom_range(0, 9))
            0: e = '0;
            1: e = OPERAND_MAX;
            default: e = random_operand();
         endcase
         load_key(m, e);
         calm = (phase_count % 6 == 3);
         if (phase_count == 12) pressure_go = 1'b1;
         burst = $urandom_range(5, 25);
         repeat (burst) send_base(random_base());
      end
      calm = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d bases under %0d key settings, %0d powers checked",
               sent_bases, phase_count, checked_powers);
      $display("included zero/one modulus, zero exponent, full-width keys, long back-pressure");
      if (fail_count == 0 && pending_powers == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
